// ===== rtl/ipcl_pkg.sv =====
// Package for the per-IP connection limit table.
// Holds sizes, operation and register codes, the table entry type and the sequencer states.
// No dependencies.
package ipcl_pkg;

  localparam int unsigned NUM_BUCKETS = 16;
  localparam int unsigned DEF_WAYS    = 8;
  localparam int unsigned BUCKET_W    = 4;
  localparam int unsigned IP_W        = 32;
  localparam int unsigned CONN_W      = 16;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  localparam logic FUNC_ACQUIRE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_ACCESS_LIMIT = 1'b0;

  typedef struct packed {
    logic              vld;
    logic [CONN_W-1:0] cnt;
    logic [IP_W-1:0]   addr;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } ipcl_state_e;

endpackage

// ===== rtl/per_ip_connection_limit_table.sv =====
// Per-IP connection limit table: bucketed address table with per-address open-connection count.
// Depends on ipcl_pkg. One table RAM, one way read per cycle, one shared count adder.
// Sequence: accept, scan of the bucket's ways, update step, result strobe; a zero limit skips the scan.
// One transaction at a time: busy_o is high from acceptance through the update step, so no new request is taken.
// Reset: clears the whole table, busy_o high meanwhile; limit resets to 0.
// Results are strobed for one cycle on done_o; the receiver cannot stall.
module per_ip_connection_limit_table import ipcl_pkg::*; #(
  parameter int unsigned WAYS_PER_BUCKET = DEF_WAYS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  func_i,
  input  logic [IP_W-1:0]       ip_address_i,
  output logic                  done_o,
  output logic                  accepted_o,
  output logic                  table_full_o,
  output logic [CONN_W-1:0]     count_after_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned TableSize = NUM_BUCKETS * WAYS_PER_BUCKET;
  localparam int unsigned IdxW      = $clog2(TableSize);
  localparam int unsigned WayCntW   = $clog2(WAYS_PER_BUCKET + 1);

  ipcl_state_e state_q, state_d;

  logic [CONN_W-1:0]   limit_q;
  logic                func_q;
  logic [IP_W-1:0]     ip_q;
  logic [BUCKET_W-1:0] bucket_q;
  logic                byp_q;

  logic [WayCntW-1:0]  iss_way_q;
  logic                cmp_vld_q;
  logic                cmp_last_q;
  logic [IdxW-1:0]     cmp_idx_q;
  logic                hit_q;
  logic [IdxW-1:0]     hit_idx_q;
  logic [CONN_W-1:0]   hit_cnt_q;
  logic                free_q;
  logic [IdxW-1:0]     free_idx_q;
  logic [IdxW-1:0]     clr_idx_q;

  entry_t              entry_mem_q [TableSize];
  entry_t              rd_data_q;

  logic                done_q;
  logic                acc_q;
  logic                full_q;
  logic [CONN_W-1:0]   cnt_q;

  logic                accept;
  logic                cfg_wr;
  logic [9:0]          byte_sum;
  logic [IdxW-1:0]     base_idx;
  logic [IdxW-1:0]     rd_idx;
  logic                issue;

  logic                mem_we;
  logic [IdxW-1:0]     wr_idx;
  entry_t              wr_data;
  logic                res_acc;
  logic                res_full;
  logic [CONN_W-1:0]   res_cnt;
  logic [CONN_W-1:0]   cnt_sum;
  logic                under_limit;
  logic                at_most_one;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ACCESS_LIMIT);
  assign prdata = (paddr[2] == REG_ACCESS_LIMIT) ? APB_DATA_W'(limit_q) : '0;

  assign accept = start_i && !busy_o;

  assign byte_sum = 10'(ip_address_i[7:0]) + 10'(ip_address_i[15:8])
                  + 10'(ip_address_i[23:16]) + 10'(ip_address_i[31:24]);

  assign base_idx = IdxW'(32'(bucket_q) * 32'(WAYS_PER_BUCKET));
  assign rd_idx   = base_idx + IdxW'(iss_way_q);
  assign issue    = (state_q == ST_SCAN) && (iss_way_q != WayCntW'(WAYS_PER_BUCKET));

  // shared count unit: +1 on acquire, -1 on release
  assign cnt_sum     = hit_cnt_q + ((func_q == FUNC_RELEASE) ? {CONN_W{1'b1}} : CONN_W'(1));
  assign under_limit = hit_cnt_q < limit_q;
  assign at_most_one = hit_cnt_q <= CONN_W'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_idx_q == IdxW'(TableSize - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = (limit_q == '0) ? ST_UPDATE : ST_SCAN;
      end
      ST_SCAN: begin
        if (cmp_vld_q && cmp_last_q) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o   = 1'b1;
    mem_we   = 1'b0;
    wr_idx   = clr_idx_q;
    wr_data  = '0;
    res_acc  = 1'b0;
    res_full = 1'b0;
    res_cnt  = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        busy_o = 1'b0;
      end
      ST_SCAN: begin
      end
      ST_UPDATE: begin
        if (byp_q) begin
          res_acc = 1'b1;
        end else if (func_q == FUNC_ACQUIRE) begin
          if (hit_q) begin
            wr_idx = hit_idx_q;
            if (under_limit) begin
              mem_we  = 1'b1;
              wr_data = '{vld: 1'b1, cnt: cnt_sum, addr: ip_q};
              res_acc = 1'b1;
              res_cnt = cnt_sum;
            end else begin
              res_cnt = hit_cnt_q;
            end
          end else if (free_q) begin
            mem_we  = 1'b1;
            wr_idx  = free_idx_q;
            wr_data = '{vld: 1'b1, cnt: CONN_W'(1), addr: ip_q};
            res_acc = 1'b1;
            res_cnt = CONN_W'(1);
          end else begin
            res_full = 1'b1;
          end
        end else begin
          if (hit_q) begin
            mem_we  = 1'b1;
            wr_idx  = hit_idx_q;
            res_acc = 1'b1;
            if (at_most_one) begin
              wr_data = '{vld: 1'b0, cnt: '0, addr: ip_q};
            end else begin
              wr_data = '{vld: 1'b1, cnt: cnt_sum, addr: ip_q};
              res_cnt = cnt_sum;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      limit_q    <= '0;
      clr_idx_q  <= '0;
      byp_q      <= 1'b0;
      iss_way_q  <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_UPDATE);
      if (cfg_wr) limit_q <= pwdata[CONN_W-1:0];
      if (state_q == ST_CLEAR) clr_idx_q <= clr_idx_q + IdxW'(1);
      if (accept) begin
        byp_q     <= (limit_q == '0);
        iss_way_q <= '0;
        cmp_vld_q <= 1'b0;
        hit_q     <= 1'b0;
        free_q    <= 1'b0;
      end else begin
        cmp_vld_q <= issue;
        if (issue) iss_way_q <= iss_way_q + WayCntW'(1);
        if (cmp_vld_q) begin
          if (rd_data_q.vld) begin
            if (!hit_q && rd_data_q.addr == ip_q) hit_q <= 1'b1;
          end else begin
            free_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= func_i;
      ip_q     <= ip_address_i;
      bucket_q <= byte_sum[BUCKET_W-1:0];
    end
    cmp_idx_q  <= rd_idx;
    cmp_last_q <= (iss_way_q == WayCntW'(WAYS_PER_BUCKET - 1));
    if (cmp_vld_q) begin
      if (rd_data_q.vld) begin
        if (!hit_q && rd_data_q.addr == ip_q) begin
          hit_idx_q <= cmp_idx_q;
          hit_cnt_q <= rd_data_q.cnt;
        end
      end else if (!free_q) begin
        free_idx_q <= cmp_idx_q;
      end
    end
    if (state_q == ST_UPDATE) begin
      acc_q  <= res_acc;
      full_q <= res_full;
      cnt_q  <= res_cnt;
    end
  end

  // table RAM
  always_ff @(posedge clk_i) begin
    if (mem_we) entry_mem_q[wr_idx] <= wr_data;
    rd_data_q <= entry_mem_q[rd_idx];
  end

  assign done_o        = done_q;
  assign accepted_o    = acc_q;
  assign table_full_o  = full_q;
  assign count_after_o = cnt_q;

  a_done_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_UPDATE))
    else $error("result strobe without an update step");

  a_write_in_update_or_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_UPDATE || state_q == ST_CLEAR))
    else $error("table written outside update or clearing pass");

  a_full_rejects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && table_full_o) |-> (!accepted_o && count_after_o == '0))
    else $error("full bucket result admitted or carries a count");

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> !done_o)
    else $error("result produced during clearing pass");

endmodule
